### src/nbce_pkg.sv
// Shared types and constants for the nested bracket content extractor.
package nbce_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// Register indexes on the configuration port.
	localparam logic REG_BRACKET_KIND = 1'b0;
	localparam logic REG_PAIR_NUMBER  = 1'b1;

	localparam logic [7:0] PAIRS_MAX = 8'd255;

	typedef enum logic [1:0] {
		RK_CONTENT   = 2'd0,
		RK_FOUND     = 2'd1,
		RK_NOT_FOUND = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		BK_ROUND  = 2'd0,
		BK_SQUARE = 2'd1,
		BK_CURLY  = 2'd2,
		BK_ANGLE  = 2'd3
	} bracket_kind_t;

	// Results caused by one input byte: an optional content byte, then an optional status.
	typedef struct packed {
		logic         has_content;
		logic [7:0]   content;
		logic         has_status;
		result_kind_t status;
	} entry_t;

	function automatic logic [7:0] open_char(input bracket_kind_t kind);
		logic [7:0] c;
		unique case (kind)
			BK_ROUND:  c = 8'h28;
			BK_SQUARE: c = 8'h5B;
			BK_CURLY:  c = 8'h7B;
			BK_ANGLE:  c = 8'h3C;
			default:   c = 8'h28;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] close_char(input bracket_kind_t kind);
		logic [7:0] c;
		unique case (kind)
			BK_ROUND:  c = 8'h29;
			BK_SQUARE: c = 8'h5D;
			BK_CURLY:  c = 8'h7D;
			BK_ANGLE:  c = 8'h3E;
			default:   c = 8'h29;
		endcase
		return c;
	endfunction

endpackage

### src/nested_bracket_content_extractor_top.sv
// Top level of the nested bracket content extractor.
// Takes one string byte per cycle and streams the bytes inside the selected top-level
// bracket pair, followed by a found or not-found status transaction; on not-found the
// consumer drops the bytes already streamed. A byte is accepted in every cycle while the
// two-entry result queue has room; a last byte with both a content byte and a not-found
// status takes two output transactions, so the sustained rate is one byte per cycle while
// out_stall is low, set by the single output transaction per cycle. Registers are at byte
// address 0 (bracket kind) and 4 (pair number); write them only while the block is idle.
module nested_bracket_content_extractor_top #(
	parameter int unsigned MAX_DEPTH = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nbce_pkg::ADDR_W-1:0]   paddr,
	input  logic [nbce_pkg::DATA_W-1:0]   pwdata,
	output logic [nbce_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_byte,
	input  logic                          last_char,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic [1:0]                    result_kind,
	output logic                          last_result
);

	localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

	nbce_pkg::bracket_kind_t kind_q;
	logic [7:0]              pair_num_q;
	logic [DW-1:0]           depth_q, depth_d;
	logic [7:0]              pairs_q, pairs_d;
	logic                    finished_q, finished_d;
	logic                    ended_q, ended_d;

	logic            cfg_wr;
	logic            in_acc, out_acc, pop;
	nbce_pkg::entry_t ent, head;
	logic            push;

	nbce_pkg::entry_t fifo_q [2];
	logic            wr_ptr_q, rd_ptr_q, phase_q;
	logic [1:0]      cnt_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= nbce_pkg::BK_ROUND;
			pair_num_q <= 8'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				nbce_pkg::REG_BRACKET_KIND: kind_q <= nbce_pkg::bracket_kind_t'(pwdata[1:0]);
				nbce_pkg::REG_PAIR_NUMBER:  pair_num_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			nbce_pkg::REG_BRACKET_KIND: prdata[1:0] = kind_q;
			nbce_pkg::REG_PAIR_NUMBER:  prdata[7:0] = pair_num_q;
			default: ;
		endcase
	end

	// Per-byte scan
	always_comb begin
		logic [7:0] op_c, cl_c;
		logic       target;
		logic       fin_next;
		op_c     = nbce_pkg::open_char(kind_q);
		cl_c     = nbce_pkg::close_char(kind_q);
		target   = (pair_num_q != 8'd0) && (pairs_q == pair_num_q);
		depth_d  = depth_q;
		pairs_d  = pairs_q;
		fin_next = finished_q;
		ended_d  = ended_q;
		ent             = '0;
		ent.content     = char_byte;
		ent.status      = nbce_pkg::RK_NOT_FOUND;
		if (!finished_q && !ended_q) begin
			priority if (char_byte == 8'd0) begin
				ended_d = 1'b1;
			end else if (char_byte == op_c) begin
				if (depth_q == '0) begin
					if (pairs_q < nbce_pkg::PAIRS_MAX)
						pairs_d = pairs_q + 8'd1;
				end else if (target) begin
					ent.has_content = 1'b1;
				end
				if (depth_q < DEPTH_MAX)
					depth_d = depth_q + DW'(1);
			end else if (char_byte == cl_c) begin
				if (depth_q != '0) begin
					depth_d = depth_q - DW'(1);
					if (target) begin
						if (depth_d == '0) begin
							fin_next       = 1'b1;
							ent.has_status = 1'b1;
							ent.status     = nbce_pkg::RK_FOUND;
						end else begin
							ent.has_content = 1'b1;
						end
					end
				end
			end else begin
				if (target && depth_q != '0)
					ent.has_content = 1'b1;
			end
		end
		finished_d = fin_next;
		if (last_char) begin
			if (!fin_next) begin
				ent.has_status = 1'b1;
				ent.status     = nbce_pkg::RK_NOT_FOUND;
			end
			depth_d    = '0;
			pairs_d    = '0;
			finished_d = 1'b0;
			ended_d    = 1'b0;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign in_acc   = in_valid & ~in_stall;
	assign push     = in_acc & (ent.has_content | ent.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			pairs_q    <= '0;
			finished_q <= 1'b0;
			ended_q    <= 1'b0;
		end else if (in_acc) begin
			depth_q    <= depth_d;
			pairs_q    <= pairs_d;
			finished_q <= finished_d;
			ended_q    <= ended_d;
		end
	end

	// Result queue: one entry per byte that causes a result, drained one transaction per cycle while out_stall is low
	assign head      = fifo_q[rd_ptr_q];
	assign out_valid = (cnt_q != 2'd0);

	always_comb begin
		if (head.has_content && !phase_q) begin
			out_byte    = head.content;
			result_kind = nbce_pkg::RK_CONTENT;
			last_result = 1'b0;
		end else begin
			out_byte    = 8'd0;
			result_kind = head.status;
			last_result = 1'b1;
		end
	end

	assign out_acc = out_valid & ~out_stall;
	assign pop     = out_acc & (last_result | ~head.has_status);

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			phase_q  <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				phase_q  <= 1'b0;
			end else if (out_acc) begin
				// content delivered, status of the same entry still pending
				phase_q <= 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sim/testbench.sv
// Self-checking testbench for the nested bracket content extractor top level.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned DEPTH_MAX = 255;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 250;

	localparam logic [7:0] OPEN_CH [4] = '{"(", "[", "{", "<"};
	localparam logic [7:0] CLOSE_CH [4] = '{")", "]", "}", ">"};

	typedef struct packed {
		logic [7:0]             data;
		nbce_pkg::result_kind_t kind;
		logic                   last;
	} result_t;

	// One input byte; where typed is set, n, r0 and r1 give the results it must cause.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} row_t;

	localparam result_t NONE    = '{8'h00, nbce_pkg::RK_CONTENT, 1'b0};
	localparam result_t FOUND   = '{8'h00, nbce_pkg::RK_FOUND, 1'b1};
	localparam result_t MISSING = '{8'h00, nbce_pkg::RK_NOT_FOUND, 1'b1};
	localparam row_t UNTYPED = '0;

	// Default setting after reset: round brackets, first pair.
	localparam row_t DIRECTED [23] = '{
		'{")",   1'b0, 1'b1, 2'd0, NONE, NONE},  // stray close right after reset
		'{"a",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{"(",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, nbce_pkg::RK_CONTENT, 1'b0}, NONE},
		'{8'h01, 1'b0, 1'b1, 2'd1, '{8'h01, nbce_pkg::RK_CONTENT, 1'b0}, NONE},
		'{"(",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{"[",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{")",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{")",   1'b0, 1'b1, 2'd1, FOUND, NONE},
		'{"(",   1'b0, 1'b0, 2'd0, NONE, NONE},  // ignored once found
		'{"y",   1'b1, 1'b1, 2'd0, NONE, NONE},
		'{"(",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{"q",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE},  // zero byte ends the string
		'{")",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{"z",   1'b1, 1'b1, 2'd1, MISSING, NONE},
		'{"(",   1'b1, 1'b1, 2'd1, MISSING, NONE},
		'{"(",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{"k",   1'b1, 1'b1, 2'd2, '{"k", nbce_pkg::RK_CONTENT, 1'b0}, MISSING},
		'{8'h80, 1'b1, 1'b1, 2'd1, MISSING, NONE},
		'{"(",   1'b0, 1'b0, 2'd0, NONE, NONE},
		'{")",   1'b1, 1'b1, 2'd1, FOUND, NONE},
		'{8'h00, 1'b1, 1'b1, 2'd1, MISSING, NONE}
	};

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [nbce_pkg::ADDR_W-1:0]   paddr = '0;
	logic [nbce_pkg::DATA_W-1:0]   pwdata = '0;
	logic [nbce_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [7:0]                    char_byte = 8'h00;
	logic                          last_char = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [7:0]                    out_byte;
	logic [1:0]                    result_kind;
	logic                          last_result;

	// Predictor copy of configuration and per-string state
	nbce_pkg::bracket_kind_t cfg_kind = nbce_pkg::BK_ROUND;
	logic [7:0]    cfg_pair = 8'd1;
	logic [7:0]    nest_depth = '0;
	logic [7:0]    pairs_seen = '0;
	logic          pair_done = 1'b0;
	logic          string_ended = 1'b0;

	result_t pending_results[$];
	row_t    bytes_in_flight[$];
	result_t step_results[$];
	row_t    accepted_row;
	result_t want;
	int      errors = 0;
	int      idle_cycles = 0;
	bit      quiet = 1'b0;

	nested_bracket_content_extractor_top #(.MAX_DEPTH(DEPTH_MAX)) DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (errors < 40)
			$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Advance the extractor state by one byte and collect the results it causes.
	task automatic extract_step(input logic [7:0] c, input logic last, ref result_t outs[$]);
		logic [7:0] op;
		logic [7:0] cl;
		logic       target;
		outs.delete();
		if (!pair_done && !string_ended) begin
			op = OPEN_CH[cfg_kind];
			cl = CLOSE_CH[cfg_kind];
			target = (cfg_pair != 8'd0) && (pairs_seen == cfg_pair);
			if (c == 8'h00) begin
				string_ended = 1'b1;
			end else if (c == op) begin
				if (nest_depth == 0) begin
					if (pairs_seen != nbce_pkg::PAIRS_MAX)
						pairs_seen++;
				end else if (target) begin
					outs.push_back('{c, nbce_pkg::RK_CONTENT, 1'b0});
				end
				if (nest_depth != DEPTH_MAX)
					nest_depth++;
			end else if (c == cl) begin
				if (nest_depth != 0) begin
					nest_depth--;
					if (target && nest_depth == 0) begin
						pair_done = 1'b1;
						outs.push_back(FOUND);
					end else if (target) begin
						outs.push_back('{c, nbce_pkg::RK_CONTENT, 1'b0});
					end
				end
			end else if (target && nest_depth != 0) begin
				outs.push_back('{c, nbce_pkg::RK_CONTENT, 1'b0});
			end
		end
		if (last) begin
			if (!pair_done)
				outs.push_back(MISSING);
			nest_depth = '0;
			pairs_seen = '0;
			pair_done = 1'b0;
			string_ended = 1'b0;
		end
	endtask

	// Input and output monitor: predict on each accepted byte, check each accepted result.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			accepted_row = bytes_in_flight.pop_front();
			extract_step(char_byte, last_char, step_results);
			if (accepted_row.typed) begin
				if (accepted_row.n > 0)
					pending_results.push_back(accepted_row.r0);
				if (accepted_row.n > 1)
					pending_results.push_back(accepted_row.r1);
			end else begin
				foreach (step_results[i])
					pending_results.push_back(step_results[i]);
			end
		end
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %h kind %0d last %b",
					out_byte, result_kind, last_result));
			end else begin
				want = pending_results.pop_front();
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
				if (result_kind !== want.kind)
					report_mismatch($sformatf("result_kind %0d, expected %0d",
						result_kind, want.kind));
				if (last_result !== want.last)
					report_mismatch($sformatf("last_result %b, expected %b",
						last_result, want.last));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	// Receiver back-pressure: random stall bursts, none while quiet.
	initial begin : result_stall
		int n;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic write_reg(input logic idx, input logic [7:0] value);
		logic [nbce_pkg::DATA_W-1:0] readback;
		readback = '0;
		if (idx == nbce_pkg::REG_BRACKET_KIND)
			readback[1:0] = value[1:0];
		else
			readback[7:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(nbce_pkg::DATA_W - 8){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands at this edge; set up the readback
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== readback)
			report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, readback));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx == nbce_pkg::REG_BRACKET_KIND)
			cfg_kind = nbce_pkg::bracket_kind_t'(value[1:0]);
		else
			cfg_pair = value;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last, input row_t desc);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= c;
		last_char <= last;
		bytes_in_flight.push_back(desc);
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic send_string(ref logic [7:0] s[$]);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1, UNTYPED);
	endtask

	// Drop valid, wait for every expected result, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0 || bytes_in_flight.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed strings of the current kind, with noise, open pairs and early zeros.
	task automatic build_string(ref logic [7:0] s[$]);
		int depth;
		int r;
		logic [7:0] op;
		logic [7:0] cl;
		s.delete();
		op = OPEN_CH[cfg_kind];
		cl = CLOSE_CH[cfg_kind];
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 24))
				s.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 5)) begin
			repeat ($urandom_range(0, 2))
				s.push_back(($urandom_range(0, 3) == 0) ? cl : 8'($urandom_range(1, 255)));
			s.push_back(op);
			depth = 1;
			repeat ($urandom_range(0, 10)) begin
				r = $urandom_range(0, 9);
				if (r < 2) begin
					s.push_back(op);
					depth++;
				end else if (r < 4 && depth > 1) begin
					s.push_back(cl);
					depth--;
				end else begin
					s.push_back(8'($urandom_range(1, 255)));
				end
			end
			// leave the pair open now and then
			if ($urandom_range(0, 9) != 0)
				repeat (depth) s.push_back(cl);
		end
		if (s.size() == 0 || $urandom_range(0, 3) == 0)
			s.push_back(8'($urandom_range(1, 255)));
		if ($urandom_range(0, 9) == 0)
			s.insert($urandom_range(0, s.size() - 1), 8'h00);
	endtask

	initial begin : stimulus
		logic [7:0]              text[$];
		int                      phase;
		int                      phase_items;
		int                      random_sent;
		nbce_pkg::bracket_kind_t kind;
		logic [7:0]              pair;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i]);
		drain();

		// Pair count up to its ceiling: the 255th curly pair holds the content.
		write_reg(nbce_pkg::REG_BRACKET_KIND, nbce_pkg::BK_CURLY);
		write_reg(nbce_pkg::REG_PAIR_NUMBER, 8'd255);
		text.delete();
		for (int p = 1; p <= 257; p++) begin
			text.push_back("{");
			if (p == 255) begin
				text.push_back("a");
				text.push_back("b");
			end
			text.push_back("}");
		end
		send_string(text);
		drain();

		// Nesting past the depth ceiling inside the first angle pair.
		write_reg(nbce_pkg::REG_BRACKET_KIND, nbce_pkg::BK_ANGLE);
		write_reg(nbce_pkg::REG_PAIR_NUMBER, 8'd1);
		text.delete();
		repeat (260) text.push_back("<");
		text.push_back("x");
		repeat (260) text.push_back(">");
		send_string(text);
		drain();

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS || phase < 6) begin
			case (phase)
				0: begin kind = nbce_pkg::BK_ROUND;  pair = 8'd1;   end
				1: begin kind = nbce_pkg::BK_SQUARE; pair = 8'd2;   end
				2: begin kind = nbce_pkg::BK_CURLY;  pair = 8'd3;   end
				3: begin kind = nbce_pkg::BK_ANGLE;  pair = 8'd0;   end
				4: begin kind = nbce_pkg::BK_ROUND;  pair = 8'd255; end
				default: begin
					kind = nbce_pkg::bracket_kind_t'($urandom_range(0, 3));
					pair = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(1, 4));
				end
			endcase
			write_reg(nbce_pkg::REG_BRACKET_KIND, kind);
			write_reg(nbce_pkg::REG_PAIR_NUMBER, pair);
			quiet = (phase % 4 == 2);
			phase_items = 0;
			while (phase_items < 40) begin
				build_string(text);
				send_string(text);
				phase_items += text.size();
			end
			random_sent += phase_items;
			drain();
			phase++;
		end

		quiet = 1'b0;
		drain();
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
